### rtl/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types, constants, microcode program and modular reduction for the
// 2x2 matrix power core.
// ----------------------------------------------------------------------------
package mpr_pkg;

  // Field and datapath widths
  localparam int EXP_BITS    = 31;
  localparam int CNT_W       = $clog2(EXP_BITS + 1);
  localparam int RES_W       = 10;
  localparam int PROD_W      = 21;
  localparam int MODULUS     = 1000;
  localparam int IN_TDATA_W  = ((EXP_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int PC_W        = 4;

  // Base matrix [[6,-4],[1,0]] in canonical form, row-major
  localparam logic [RES_W-1:0] BASE_M [4] = '{
    RES_W'(6), RES_W'(MODULUS - 4), RES_W'(1), RES_W'(0)
  };

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SKIP,
    OP_SQ,
    OP_MB,
    OP_RED,
    OP_SHIFT,
    OP_FIN,
    OP_EMIT,
    OP_EMIT_BAD
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_NO_IN,
    C_ZERO,
    C_MSB_CLR,
    C_MORE,
    C_BUSY
  } cond_t;

  // One control word: jump to target when cond holds, else advance
  // (or return to the start when last is set)
  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             last;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic load;
    logic emit;
  } dp_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic exp_zero;
    logic exp_msb;
    logic more;
  } dp_stat_t;

  // Program addresses
  localparam logic [PC_W-1:0] ST_LOAD  = PC_W'(0);
  localparam logic [PC_W-1:0] ST_CHECK = PC_W'(1);
  localparam logic [PC_W-1:0] ST_SKIP  = PC_W'(2);
  localparam logic [PC_W-1:0] ST_SQ    = PC_W'(3);
  localparam logic [PC_W-1:0] ST_SQRED = PC_W'(4);
  localparam logic [PC_W-1:0] ST_MB    = PC_W'(5);
  localparam logic [PC_W-1:0] ST_MBRED = PC_W'(6);
  localparam logic [PC_W-1:0] ST_SHIFT = PC_W'(7);
  localparam logic [PC_W-1:0] ST_FIN   = PC_W'(8);
  localparam logic [PC_W-1:0] ST_FNRED = PC_W'(9);
  localparam logic [PC_W-1:0] ST_EMIT  = PC_W'(10);
  localparam logic [PC_W-1:0] ST_BAD   = PC_W'(11);

  // Microcode program
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      ST_LOAD:  w = '{OP_LOAD,     C_NO_IN,   ST_LOAD,  1'b0};
      ST_CHECK: w = '{OP_NOP,      C_ZERO,    ST_BAD,   1'b0};
      ST_SKIP:  w = '{OP_SKIP,     C_MSB_CLR, ST_SKIP,  1'b0};
      ST_SQ:    w = '{OP_SQ,       C_NEXT,    ST_LOAD,  1'b0};
      ST_SQRED: w = '{OP_RED,      C_MSB_CLR, ST_SHIFT, 1'b0};
      ST_MB:    w = '{OP_MB,       C_NEXT,    ST_LOAD,  1'b0};
      ST_MBRED: w = '{OP_RED,      C_NEXT,    ST_LOAD,  1'b0};
      ST_SHIFT: w = '{OP_SHIFT,    C_MORE,    ST_SQ,    1'b0};
      ST_FIN:   w = '{OP_FIN,      C_NEXT,    ST_LOAD,  1'b0};
      ST_FNRED: w = '{OP_RED,      C_NEXT,    ST_LOAD,  1'b0};
      ST_EMIT:  w = '{OP_EMIT,     C_BUSY,    ST_EMIT,  1'b1};
      ST_BAD:   w = '{OP_EMIT_BAD, C_BUSY,    ST_BAD,   1'b1};
      default:  w = '{OP_NOP,      C_NEXT,    ST_LOAD,  1'b1};
    endcase
    return w;
  endfunction

  // Reduce a product sum modulo 1000: fold the upper bits twice using
  // 1024 = 24 (mod 1000), then subtract the modulus at most twice
  function automatic logic [RES_W-1:0] mod1000(input logic [PROD_W-1:0] p);
    logic [10:0] h1;
    logic [15:0] s1;
    logic [5:0]  h2;
    logic [11:0] s2;
    logic [11:0] s3;
    h1 = p[20:10];
    s1 = {1'b0, h1, 4'b0} + {2'b0, h1, 3'b0} + {6'b0, p[9:0]};
    h2 = s1[15:10];
    s2 = {2'b0, h2, 4'b0} + {3'b0, h2, 3'b0} + {2'b0, s1[9:0]};
    if (s2 >= 12'(2 * MODULUS)) begin
      s3 = s2 - 12'(2 * MODULUS);
    end else if (s2 >= 12'(MODULUS)) begin
      s3 = s2 - 12'(MODULUS);
    end else begin
      s3 = s2;
    end
    return s3[RES_W-1:0];
  endfunction

endpackage

### rtl/mpr_seq.sv
// ----------------------------------------------------------------------------
// mpr_seq
// Microcode sequencer: step counter, program table and jump conditions.
// ----------------------------------------------------------------------------
module mpr_seq import mpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          uw;
  logic            take;

  // Fetch the current control word
  assign uw       = ucode(pc_r);
  assign in_ready = (uw.op == OP_LOAD);

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      C_NEXT:    take = 1'b0;
      C_NO_IN:   take = !in_valid;
      C_ZERO:    take = stat.exp_zero;
      C_MSB_CLR: take = !stat.exp_msb;
      C_MORE:    take = stat.more;
      C_BUSY:    take = out_busy;
      default:   take = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    if (take) begin
      pc_nxt = uw.target;
    end else if (uw.last) begin
      pc_nxt = ST_LOAD;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // Drive the datapath
  always_comb begin
    ctrl.op   = uw.op;
    ctrl.load = in_ready && in_valid;
    ctrl.emit = ((uw.op == OP_EMIT) || (uw.op == OP_EMIT_BAD)) && !out_busy;
  end

  // Hold the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### rtl/mpr_dp.sv
// ----------------------------------------------------------------------------
// mpr_dp
// Datapath: exponent shifter, bit counter, matrix registers, four
// multiply lanes and the modulo-1000 reduction.
// ----------------------------------------------------------------------------
module mpr_dp import mpr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_ctrl_t            ctrl,
  input  logic [EXP_BITS-1:0] exponent,
  output dp_stat_t            stat,
  output logic [RES_W-1:0]    v
);

  logic [EXP_BITS-1:0] e_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [RES_W-1:0]    m_r [4];
  logic [PROD_W-1:0]   p_r [4];
  logic [PROD_W-1:0]   sum [4];
  logic [RES_W-1:0]    a0  [4];
  logic [RES_W-1:0]    b0  [4];
  logic [RES_W-1:0]    a1  [4];
  logic [RES_W-1:0]    b1  [4];

  // Select lane operands: entry (i,j) = x[i][0]*y[0][j] + x[i][1]*y[1][j]
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a0[k] = m_r[k & 2];
      a1[k] = m_r[(k & 2) + 1];
      if (ctrl.op == OP_MB) begin
        b0[k] = BASE_M[k & 1];
        b1[k] = BASE_M[2 + (k & 1)];
      end else begin
        b0[k] = m_r[k & 1];
        b1[k] = m_r[2 + (k & 1)];
      end
    end
    // Final combination 6*a10 + 2*a11 on lane zero
    if (ctrl.op == OP_FIN) begin
      a0[0] = RES_W'(6);
      b0[0] = m_r[2];
      a1[0] = RES_W'(2);
      b1[0] = m_r[3];
    end
  end

  // Multiply and add in each lane
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = PROD_W'(20'(a0[k]) * 20'(b0[k])) + PROD_W'(20'(a1[k]) * 20'(b1[k]));
    end
  end

  // Load and advance the exponent and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r   <= '0;
      cnt_r <= '0;
    end else begin
      unique case (ctrl.op)
        OP_LOAD: begin
          if (ctrl.load) begin
            e_r   <= exponent;
            cnt_r <= CNT_W'(EXP_BITS);
          end
        end
        OP_SKIP: begin
          if (!e_r[EXP_BITS-1]) begin
            e_r   <= e_r << 1;
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        OP_SHIFT: begin
          e_r   <= e_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Update matrix and product registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.load) begin
          m_r[0] <= RES_W'(1);
          m_r[1] <= '0;
          m_r[2] <= '0;
          m_r[3] <= RES_W'(1);
        end
      end
      OP_SQ, OP_MB, OP_FIN: begin
        for (int k = 0; k < 4; k++) begin
          p_r[k] <= sum[k];
        end
      end
      OP_RED: begin
        for (int k = 0; k < 4; k++) begin
          m_r[k] <= mod1000(p_r[k]);
        end
      end
      default: begin
      end
    endcase
  end

  // Report status
  always_comb begin
    stat.exp_zero = (e_r == '0);
    stat.exp_msb  = e_r[EXP_BITS-1];
    stat.more     = (cnt_r != CNT_W'(1));
  end

  assign v = m_r[0];

endmodule

### rtl/matrix_power_recurrence_mod_core.sv
// ----------------------------------------------------------------------------
// matrix_power_recurrence_mod_core
// Last three decimal digits of floor((3+sqrt5)^n) by 2x2 matrix power
// modulo 1000, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  in_      slave      tdata[30:0] exponent
//  out_     master     tdata[9:0] last_digits, tuser bad_exponent
//
//  One transaction at a time. The exponent is shifted past its leading
//  zeros; each bit from the leading one down then takes a squaring, a
//  multiply by the base matrix when the bit is one, and a shift. Each
//  matrix product is a multiply step and a reduce step on the shared
//  lanes. A zero exponent is returned flagged bad, with zero digits.
//  Reset is synchronous, active low, and clears the sequencer and output
//  valid. A stalled result holds in the output register while the next
//  input is accepted and computed.
// ----------------------------------------------------------------------------
module matrix_power_recurrence_mod_core import mpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] exponent
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] last_digits
  output logic                   out_tuser   // [0] bad_exponent
);

  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [RES_W-1:0] v;
  logic             out_busy;
  logic             out_valid_r;
  logic [RES_W-1:0] out_digits_r;
  logic             out_bad_r;
  logic [RES_W-1:0] digits_nxt;

  assign out_busy = out_valid_r && !out_tready;

  mpr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .stat     (stat),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  mpr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .exponent (in_tdata[EXP_BITS-1:0]),
    .stat     (stat),
    .v        (v)
  );

  // Form the answer (v - 1) mod 1000
  always_comb begin
    if (ctrl.op == OP_EMIT_BAD) begin
      digits_nxt = '0;
    end else if (v == '0) begin
      digits_nxt = RES_W'(MODULUS - 1);
    end else begin
      digits_nxt = v - RES_W'(1);
    end
  end

  // Hold the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_digits_r <= digits_nxt;
      out_bad_r    <= (ctrl.op == OP_EMIT_BAD);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_digits_r);
  assign out_tuser  = out_bad_r;

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> !out_busy)
    else $error("result overwritten while stalled");

  // A result shows up the cycle after it is produced
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> out_tvalid)
    else $error("emitted result not presented");

  // A flagged exponent carries zero digits
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_digits_r == '0))
    else $error("bad exponent with nonzero digits");

  // Digits stay in canonical range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_digits_r < RES_W'(MODULUS)))
    else $error("digits out of range");

  // Input is taken only when no item is in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second input accepted during computation");

endmodule
